// ===== rtl/core/bmh_pkg.sv =====
package bmh_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_RADIUS = 4;
  localparam int ROW_LIMIT  = 4096;
  localparam int LINE_DEPTH = 2 * MAX_RADIUS * MAX_WIDTH;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(ROW_LIMIT);
  localparam int RAD_W  = 3;
  localparam int PIX_W  = 8;
  localparam int CSUM_W = 12;
  localparam int WSUM_W = 15;
  localparam int HGT_W  = 17;
  localparam int DVD_W  = WSUM_W + 8;
  localparam int DSR_W  = 7;
  localparam int LINE_AW = $clog2(LINE_DEPTH);
  localparam int PHASE_W = LINE_AW - COL_W;
  localparam int RING_N  = 2 * MAX_RADIUS + 1;
  localparam int RING_W  = $clog2(RING_N);

  localparam logic [DVD_W+1:0] OFFSET_Q8 = (DVD_W+2)'(34816);
  localparam logic [DVD_W+1:0] HGT_MAX   = (DVD_W+2)'(65535);

  // configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_RADIUS = 2'd2;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [RAD_W-1:0] rad;
    logic             emit;
    logic             last;
  } bmh_item_t;

  typedef enum logic [2:0] {
    B_CLR, B_IDLE, B_PREP, B_MODR, B_MODC, B_UPD, B_SUM, B_DIVW
  } bmh_state_t;

  // window size (2r+1)^2 for a clamped radius
  function automatic logic [DSR_W-1:0] win_count(input logic [RAD_W-1:0] rad);
    logic [DSR_W-1:0] n;
    case (rad)
      3'd0:    n = 7'd1;
      3'd1:    n = 7'd9;
      3'd2:    n = 7'd25;
      3'd3:    n = 7'd49;
      default: n = 7'd81;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/core/bmh_ram.sv =====
module bmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/bmh_div.sv =====
// Restoring divider, one quotient bit per cycle.
module bmh_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [bmh_pkg::DVD_W-1:0] dividend,
  input  logic [bmh_pkg::DSR_W-1:0] divisor,
  output logic                      busy,
  output logic                      done,
  output logic [bmh_pkg::DVD_W-1:0] quot,
  output logic [bmh_pkg::DSR_W-1:0] rem
);

  logic [bmh_pkg::DSR_W-1:0]         dsr;
  logic [$clog2(bmh_pkg::DVD_W)-1:0] cnt;
  logic [bmh_pkg::DSR_W:0]           trial;

  assign trial = {rem, quot[bmh_pkg::DVD_W-1]};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ($clog2(bmh_pkg::DVD_W))'(bmh_pkg::DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dsr}) begin
        rem  <= bmh_pkg::DSR_W'(trial - {1'b0, dsr});
        quot <= {quot[bmh_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem  <= trial[bmh_pkg::DSR_W-1:0];
        quot <= {quot[bmh_pkg::DVD_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/core/bmh_queue.sv =====
// Two-entry queue between front and back.
module bmh_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bmh_pkg::bmh_item_t push_item,
  input  logic               pop,
  output bmh_pkg::bmh_item_t head,
  output logic               full,
  output logic               empty
);

  bmh_pkg::bmh_item_t slot [2];
  logic               wptr;
  logic               rptr;
  logic [1:0]         count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = slot[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= push_item;
    end
  end

endmodule

// ===== rtl/core/bmh_front.sv =====
// Accept pixels, track raster position, tag each item for the back end.
module bmh_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,  // sample[7:0]
  input  logic                      s_tuser,  // frame_start
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [12:0]               cfg_data,
  input  logic                      hold,
  input  logic                      q_full,
  output logic                      push,
  output bmh_pkg::bmh_item_t        push_item
);

  logic [10:0] image_width;
  logic [12:0] image_height;
  logic [2:0]  filter_radius;

  logic [bmh_pkg::COL_W-1:0] col_count;
  logic [bmh_pkg::ROW_W-1:0] row_count;

  logic [10:0] ew;
  logic [12:0] eh;
  logic [2:0]  rad;
  logic [3:0]  span;
  logic        active;
  logic [10:0] c;
  logic [12:0] r;
  logic [12:0] r_pre;
  logic [10:0] c_inc;
  logic [12:0] r_inc;
  logic [10:0] col_count_next;
  logic [12:0] row_count_next;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full && !hold;
  assign push      = s_tvalid && s_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= 11'd640;
      image_height  <= 13'd480;
      filter_radius <= 3'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bmh_pkg::CFG_WIDTH:  image_width   <= cfg_data[10:0];
        bmh_pkg::CFG_HEIGHT: image_height  <= cfg_data;
        bmh_pkg::CFG_RADIUS: filter_radius <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  always_comb begin
    ew = (image_width > 11'(bmh_pkg::MAX_WIDTH)) ? 11'(bmh_pkg::MAX_WIDTH) : image_width;
    eh = (image_height > 13'(bmh_pkg::ROW_LIMIT)) ? 13'(bmh_pkg::ROW_LIMIT) : image_height;
    active = (ew != 11'd0) && (eh != 13'd0);
    if (ew == 11'd0) ew = 11'd1;
    if (eh == 13'd0) eh = 13'd1;
    rad  = (filter_radius > 3'(bmh_pkg::MAX_RADIUS)) ? 3'(bmh_pkg::MAX_RADIUS) : filter_radius;
    span = {rad, 1'b0};
  end

  // position of this pixel and of the next
  always_comb begin
    if (s_tuser) begin
      c     = 11'd0;
      r_pre = 13'd0;
    end else if ({1'b0, col_count} >= ew) begin
      c     = 11'd0;
      r_pre = {1'b0, row_count} + 13'd1;
    end else begin
      c     = {1'b0, col_count};
      r_pre = {1'b0, row_count};
    end
    r     = (r_pre >= eh) ? 13'd0 : r_pre;
    c_inc = c + 11'd1;
    r_inc = r + 13'd1;
    if (c_inc >= ew) begin
      col_count_next = 11'd0;
      row_count_next = (r_inc >= eh) ? 13'd0 : r_inc;
    end else begin
      col_count_next = c_inc;
      row_count_next = r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (push) begin
      col_count <= col_count_next[bmh_pkg::COL_W-1:0];
      row_count <= row_count_next[bmh_pkg::ROW_W-1:0];
    end
  end

  always_comb begin
    push_item.pix  = s_tdata;
    push_item.col  = c[bmh_pkg::COL_W-1:0];
    push_item.row  = r[bmh_pkg::ROW_W-1:0];
    push_item.rad  = rad;
    push_item.emit = active && (c >= {7'd0, span}) && (r >= {9'd0, span});
    push_item.last = (c == ew - 11'd1) && (r == eh - 13'd1);
  end

endmodule

// ===== rtl/core/bmh_back.sv =====
// Update column sums and line store, form the window mean, deliver results.
module bmh_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  bmh_pkg::bmh_item_t head,
  output logic               pop,
  output logic               clearing,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [39:0]        m_tdata,  // out_col[9:0], out_row[21:10], height_q8[38:22], 0
  output logic               m_tlast
);

  bmh_pkg::bmh_state_t state, state_next;
  bmh_pkg::bmh_item_t  item;

  logic [bmh_pkg::COL_W-1:0]   clr_cnt;
  logic [bmh_pkg::PHASE_W-1:0] phase;
  logic [bmh_pkg::RING_W-1:0]  ring_idx;
  logic [bmh_pkg::CSUM_W-1:0]  ring [bmh_pkg::RING_N];

  logic [3:0]                  span;
  logic [bmh_pkg::DSR_W-1:0]   len;

  logic                        div_start, div_busy, div_done;
  logic [bmh_pkg::DVD_W-1:0]   div_dvd, div_quot;
  logic [bmh_pkg::DSR_W-1:0]   div_dsr, div_rem;

  logic                        col_we, col_re, line_we, line_re;
  logic [bmh_pkg::COL_W-1:0]   col_waddr;
  logic [bmh_pkg::CSUM_W-1:0]  col_wdata, col_rdata;
  logic [bmh_pkg::LINE_AW-1:0] line_raddr, line_waddr;
  logic [bmh_pkg::PIX_W-1:0]   line_rdata;

  logic [bmh_pkg::CSUM_W-1:0]  base, full, sub;
  logic [15:0]                 total;
  logic [bmh_pkg::DVD_W+1:0]   h_wide;
  logic                        out_load;

  assign span     = {item.rad, 1'b0};
  assign len      = {3'd0, span} + 7'd1;
  assign clearing = (state == bmh_pkg::B_CLR);

  bmh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  bmh_ram #(.WIDTH(bmh_pkg::CSUM_W), .DEPTH(bmh_pkg::MAX_WIDTH)) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (col_waddr),
    .wdata (col_wdata),
    .re    (col_re),
    .raddr (item.col),
    .rdata (col_rdata)
  );

  bmh_ram #(.WIDTH(bmh_pkg::PIX_W), .DEPTH(bmh_pkg::LINE_DEPTH)) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (item.pix),
    .re    (line_re),
    .raddr (line_raddr),
    .rdata (line_rdata)
  );

  // column update arithmetic; the window sum covers only the active ring slots
  always_comb begin
    base = (item.row == '0) ? '0 : col_rdata;
    full = base + {4'd0, item.pix};
    if (span == 4'd0) begin
      sub = {4'd0, item.pix};
    end else if (item.row >= {8'd0, span}) begin
      sub = {4'd0, line_rdata};
    end else begin
      sub = '0;
    end
    total = '0;
    for (int k = 0; k < bmh_pkg::RING_N; k++) begin
      if (bmh_pkg::DSR_W'(k) < len) begin
        total = total + {4'd0, ring[k]};
      end
    end
    h_wide = {2'b00, div_quot} - bmh_pkg::OFFSET_Q8;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bmh_pkg::B_CLR:  if (clr_cnt == '1) state_next = bmh_pkg::B_IDLE;
      bmh_pkg::B_IDLE: if (!q_empty) state_next = bmh_pkg::B_PREP;
      bmh_pkg::B_PREP: state_next = (span == 4'd0) ? bmh_pkg::B_MODC : bmh_pkg::B_MODR;
      bmh_pkg::B_MODR: if (div_done) state_next = bmh_pkg::B_MODC;
      bmh_pkg::B_MODC: if (div_done) state_next = bmh_pkg::B_UPD;
      bmh_pkg::B_UPD:  state_next = item.emit ? bmh_pkg::B_SUM : bmh_pkg::B_IDLE;
      bmh_pkg::B_SUM:  if (!m_tvalid) state_next = bmh_pkg::B_DIVW;
      bmh_pkg::B_DIVW: if (div_done) state_next = bmh_pkg::B_IDLE;
      default:         state_next = bmh_pkg::B_IDLE;
    endcase
  end

  // outputs of each state
  always_comb begin
    pop        = 1'b0;
    div_start  = 1'b0;
    div_dvd    = {{(bmh_pkg::DVD_W-bmh_pkg::COL_W){1'b0}}, item.col};
    div_dsr    = len;
    col_re     = 1'b0;
    line_re    = 1'b0;
    col_we     = 1'b0;
    col_waddr  = item.col;
    col_wdata  = full - sub;
    line_we    = 1'b0;
    line_raddr = {div_rem[bmh_pkg::PHASE_W-1:0], item.col};
    line_waddr = {phase, item.col};
    out_load   = 1'b0;
    unique case (state)
      bmh_pkg::B_CLR: begin
        col_we    = 1'b1;
        col_waddr = clr_cnt;
        col_wdata = '0;
      end
      bmh_pkg::B_IDLE: begin
        pop = !q_empty;
      end
      bmh_pkg::B_PREP: begin
        div_start = 1'b1;
        if (span != 4'd0) begin
          div_dvd = {{(bmh_pkg::DVD_W-bmh_pkg::ROW_W){1'b0}}, item.row};
          div_dsr = {3'd0, span};
        end else begin
          col_re = 1'b1;
        end
      end
      bmh_pkg::B_MODR: begin
        if (div_done) begin
          div_start = 1'b1;
          col_re    = 1'b1;
          line_re   = 1'b1;
        end
      end
      bmh_pkg::B_MODC: ;
      bmh_pkg::B_UPD: begin
        col_we  = 1'b1;
        line_we = (span != 4'd0);
      end
      bmh_pkg::B_SUM: begin
        // hold the mean until the output register is free
        div_start = !m_tvalid;
        div_dvd   = {total[bmh_pkg::WSUM_W-1:0], 8'd0};
        div_dsr   = bmh_pkg::win_count(item.rad);
      end
      bmh_pkg::B_DIVW: begin
        out_load = div_done;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= bmh_pkg::B_CLR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == bmh_pkg::B_CLR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // per-item registers
  always_ff @(posedge clk) begin
    if (pop) begin
      item <= head;
    end
    if (state == bmh_pkg::B_MODR && div_done) begin
      phase <= div_rem[bmh_pkg::PHASE_W-1:0];
    end
    if (state == bmh_pkg::B_MODC && div_done) begin
      ring_idx <= div_rem[bmh_pkg::RING_W-1:0];
    end
  end

  // ring of full column sums along the current row
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < bmh_pkg::RING_N; k++) begin
        ring[k] <= '0;
      end
    end else if (state == bmh_pkg::B_UPD) begin
      ring[ring_idx] <= full;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata[9:0]   <= item.col - {6'd0, span};
      m_tdata[21:10] <= item.row - {8'd0, span};
      if (!h_wide[bmh_pkg::DVD_W+1] && h_wide > bmh_pkg::HGT_MAX) begin
        m_tdata[38:22] <= 17'h0ffff;
      end else begin
        m_tdata[38:22] <= h_wide[bmh_pkg::HGT_W-1:0];
      end
      m_tdata[39] <= 1'b0;
      m_tlast     <= item.last;
    end
  end

  // the divider is never restarted while running
  assert property (@(posedge clk) disable iff (rst) div_start |-> !div_busy)
    else $error("divider restarted while busy");
  // ring slot chosen lies inside the window
  assert property (@(posedge clk) disable iff (rst)
      state == bmh_pkg::B_UPD |-> {3'd0, ring_idx} < len)
    else $error("ring index out of window");
  // no item leaves the queue during the clearing pass
  assert property (@(posedge clk) disable iff (rst) clearing |-> !pop)
    else $error("item taken during clear");
  // a new result is only loaded once the previous one is gone
  assert property (@(posedge clk) disable iff (rst) out_load |-> !m_tvalid)
    else $error("result overwritten");

endmodule

// ===== rtl/core/box_mean_height_filter_core.sv =====
// Box-mean height filter. Pixels (low byte used) enter in raster order with a
// frame-start flag; for every position whose (2r+1)x(2r+1) window fits the
// image one result gives floor(sum*256/count) - 136*256 as signed Q9.8 with
// its output coordinates, tlast on the final one of the frame. Pixels are
// taken one at a time: for each pixel the shared bit-serial divider finds in
// turn the line-store phase (not at radius zero) and the ring slot, and for
// one that yields a result also the mean. A two-entry queue lets input keep
// arriving while the back end works; a result waiting in the output register
// holds the back end only before the mean is formed. After reset all 1024
// column-sum entries are cleared, and no pixel is accepted until the clear
// is done. Configuration writes are taken in any cycle.
module box_mean_height_filter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // sample[7:0]
  input  logic        s_tuser,   // frame_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // out_col[9:0], out_row[21:10], height_q8[38:22], 0
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  bmh_pkg::bmh_item_t push_item, head;
  logic push, pop, q_full, q_empty, clearing;

  bmh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .hold      (clearing),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  bmh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  bmh_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .head     (head),
    .pop      (pop),
    .clearing (clearing),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
